@@ rtl/dsq_pkg.sv @@
// Shared types and constants of the date sorting queue.
`default_nettype none

package dsq_pkg;

  localparam int CAPACITY = 1024;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/dsq_cell.sv @@
// One cell of the sorted chain: holds one date and shifts it left or right.
`default_nettype none

module dsq_cell (
  input  wire logic              clk,
  input  wire dsq_pkg::cell_ctl_t ctl,
  input  wire logic              occ,
  input  wire dsq_pkg::date_t    ins_key,
  input  wire dsq_pkg::date_t    left_key,
  input  wire logic              left_le,
  input  wire dsq_pkg::date_t    right_key,
  output dsq_pkg::date_t         key,
  output logic                   le
);
  import dsq_pkg::*;

  date_t key_r;
  date_t key_nxt;

  // The stored date sorts at or before the incoming date.
  assign le  = occ && (key_r <= ins_key);
  assign key = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl.push) begin
      if (!le) begin
        key_nxt = left_le ? ins_key : left_key;
      end
    end else if (ctl.pop) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/dsq_chain.sv @@
// Row of sorting cells; cell zero always holds the earliest date.
`default_nettype none

module dsq_chain (
  input  wire logic               clk,
  input  wire dsq_pkg::cell_ctl_t ctl,
  input  wire dsq_pkg::count_t    count,
  input  wire dsq_pkg::date_t     ins_key,
  output dsq_pkg::date_t          head_key
);
  import dsq_pkg::*;

  date_t key_w [CAPACITY];
  logic  le_w  [CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      date_t left_key;
      logic  left_le;
      date_t right_key;
      logic  occ;

      assign occ = count > CNT_W'(gi);

      if (gi == 0) begin : g_first
        assign left_key = ins_key;
        assign left_le  = 1'b1;
      end else begin : g_mid
        assign left_key = key_w[gi-1];
        assign left_le  = le_w[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_key = '0;
      end else begin : g_inner
        assign right_key = key_w[gi+1];
      end

      dsq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ),
        .ins_key   (ins_key),
        .left_key  (left_key),
        .left_le   (left_le),
        .right_key (right_key),
        .key       (key_w[gi]),
        .le        (le_w[gi])
      );
    end
  endgenerate

  assign head_key = key_w[0];

endmodule

`default_nettype wire

@@ rtl/date_sorting_queue.sv @@
// Top level of the date sorting queue.
// Holds up to 1024 dates in a row of cells kept in ascending year, month,
// day order. A push word inserts a date; a pop word returns the earliest
// date and removes it. Every word gives one status word: ok, pop while empty
// (date zero), or push dropped because full. Each cell compares its date
// with the broadcast incoming date in parallel and shifts by one place, so
// one word is taken per cycle whenever the result register is free or being
// taken; the result is registered and appears in the cycle after acceptance.
`default_nettype none

module date_sorting_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [13:0] in_year,
  input  wire logic [3:0]  in_month,
  input  wire logic [4:0]  in_day,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [1:0]       out_status
);
  import dsq_pkg::*;

  count_t    count_r, count_nxt;
  logic      out_valid_r, out_valid_nxt;
  date_t     res_key_r, res_key_nxt;
  status_t   res_st_r, res_st_nxt;
  cell_ctl_t ctl;
  date_t     ins_key;
  date_t     head_key;
  logic      fire;
  logic      is_empty;
  logic      is_full;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign ins_key  = '{year: in_year, month: in_month, day: in_day};

  assign ctl.push = fire && (in_op == OP_PUSH) && !is_full;
  assign ctl.pop  = fire && (in_op == OP_POP) && !is_empty;

  dsq_chain u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .count    (count_r),
    .ins_key  (ins_key),
    .head_key (head_key)
  );

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    res_key_nxt   = res_key_r;
    res_st_nxt    = res_st_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
      res_key_nxt   = '0;
      res_st_nxt    = ST_OK;
      if (in_op == OP_PUSH) begin
        if (is_full) begin
          res_st_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (is_empty) begin
          res_st_nxt = ST_EMPTY;
        end else begin
          res_key_nxt = head_key;
          count_nxt   = count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_key_r <= res_key_nxt;
    res_st_r  <= res_st_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_year   = res_key_r.year;
  assign out_month  = res_key_r.month;
  assign out_day    = res_key_r.day;
  assign out_status = res_st_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(count_r))
    else $error("stored count changed without an accepted word");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_op == OP_POP) && is_empty |=> out_valid && (out_status == ST_EMPTY)
      && (out_year == '0) && (out_month == '0) && (out_day == '0))
    else $error("pop from empty store gave a wrong result");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_op == OP_PUSH) && is_full |=> (out_status == ST_FULL) && $stable(count_r))
    else $error("push into full store was not dropped");

endmodule

`default_nettype wire

@@ verif/dsq_checker.sv @@
// Checker for the date sorting queue: tracks held dates, predicts each status word and compares.
module dsq_checker
  import dsq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_op,
  input  wire logic [13:0] in_year,
  input  wire logic [3:0]  in_month,
  input  wire logic [4:0]  in_day,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [13:0] out_year,
  input  wire logic [3:0]  out_month,
  input  wire logic [4:0]  out_day,
  input  wire logic [1:0]  out_status,
  output int unsigned      errors,
  output int unsigned      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    date_t   date;
    status_t status;
  } outcome_t;

  date_t       held_dates[$];
  outcome_t    due_outcomes[$];
  outcome_t    oldest;
  int unsigned fail_count = 0;

  function automatic outcome_t apply_word(input op_t op, input date_t d);
    outcome_t o;
    int       idx;
    o.date   = '0;
    o.status = ST_OK;
    if (op == OP_PUSH) begin
      if (held_dates.size() >= CAPACITY) begin
        o.status = ST_FULL;
      end else begin
        idx = held_dates.size();
        while (idx > 0 && held_dates[idx-1] > d) idx--;
        held_dates.insert(idx, d);
      end
    end else if (held_dates.size() == 0) begin
      o.status = ST_EMPTY;
    end else begin
      o.date = held_dates.pop_front();
    end
    return o;
  endfunction

  task automatic compare_field(input string field, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: out_%s expected %0d, actual %0d", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_dates.delete();
      due_outcomes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_outcomes.size() == 0) begin
          fail_count++;
          $display("%0t: word on the result channel with nothing expected, actual status %0d",
                   $time, out_status);
        end else begin
          oldest = due_outcomes.pop_front();
          compare_field("year", oldest.date.year, out_year);
          compare_field("month", oldest.date.month, out_month);
          compare_field("day", oldest.date.day, out_day);
          compare_field("status", oldest.status, out_status);
        end
      end
      if (in_valid && in_ready) begin
        due_outcomes.push_back(apply_word(op_t'(in_op), {in_year, in_month, in_day}));
      end
    end
    errors  <= fail_count;
    pending <= due_outcomes.size();
  end

endmodule

@@ verif/date_sorting_queue_tb.sv @@
// Testbench top for the date sorting queue: clock, reset, stimulus, receiver stalls and verdict.
module date_sorting_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dsq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MIX_WORDS   = 60;
  localparam int FULL_PUSHES = 8;
  localparam int TAIL_WORDS  = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [13:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic        out_valid;
  logic        out_ready;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [1:0]  out_status;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned level = 0;
  int unsigned peak = 0;
  int unsigned push_words = 0;
  int unsigned pop_words = 0;
  int unsigned full_hits = 0;
  int unsigned empty_hits = 0;
  int unsigned burst_left = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  date_sorting_queue u_dut (.*);

  dsq_checker u_checker (.*);

  function automatic date_t any_date();
    date_t d;
    int    kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        d = 23'($urandom);
      end
      1, 2, 3: begin
        d.year  = 14'(2000 + $urandom_range(0, 1));
        d.month = 4'($urandom_range(1, 2));
        d.day   = 5'($urandom_range(1, 4));
      end
      default: begin
        d.year  = 14'($urandom_range(1, 9999));
        d.month = 4'($urandom_range(1, 12));
        d.day   = 5'($urandom_range(1, 31));
      end
    endcase
    return d;
  endfunction

  function automatic op_t pick_op(input int push_pct);
    return ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
  endfunction

  task automatic send_word(input op_t op, input date_t d);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op    <= op;
    in_year  <= d.year;
    in_month <= d.month;
    in_day   <= d.day;
    do @(posedge clk); while (!in_ready);
    if (op == OP_PUSH) begin
      push_words++;
      if (level < CAPACITY) level++;
      else full_hits++;
    end else begin
      pop_words++;
      if (level > 0) level--;
      else empty_hits++;
    end
    if (level > peak) peak = level;
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_op    <= OP_PUSH;
    in_year  <= '0;
    in_month <= '0;
    in_day   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Ordering by year, month and day, equal dates, and fields at both ends of their widths.
    send_word(OP_POP, any_date());
    send_word(OP_PUSH, '{14'd2024, 4'd2, 5'd29});
    send_word(OP_PUSH, '{14'h3FFF, 4'hF, 5'h1F});
    send_word(OP_PUSH, '{14'd0, 4'd0, 5'd0});
    send_word(OP_PUSH, '{14'd2024, 4'd2, 5'd29});
    send_word(OP_PUSH, '{14'd9999, 4'd12, 5'd31});
    send_word(OP_PUSH, '{14'd1, 4'd1, 5'd1});
    send_word(OP_PUSH, '{14'd2024, 4'd2, 5'd28});
    send_word(OP_PUSH, '{14'd2024, 4'd3, 5'd1});
    send_word(OP_PUSH, '{14'd2023, 4'd12, 5'd31});
    repeat (10) send_word(OP_POP, any_date());

    repeat (MIX_WORDS) send_word(pick_op(50), any_date());
    while (level < CAPACITY) send_word(pick_op(97), any_date());
    repeat (FULL_PUSHES) send_word(OP_PUSH, any_date());
    repeat (TAIL_WORDS) send_word(pick_op(50), any_date());

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d words: %0d pushes and %0d pops; the store peaked at %0d of %0d dates.",
             push_words + pop_words, push_words, pop_words, peak, CAPACITY);
    $display("%0d pushes met a full store and %0d pops met an empty one.",
             full_hits, empty_hits);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int mode;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d words still expected.", pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
